[sv/deq_pkg.sv]
// Shared types, operation and status codes for the double-ended queue.
`default_nettype none

package deq_pkg;

	// Default number of ring entries.
	localparam int unsigned DEPTH_DEFAULT = 256;

	// Field widths of the transfer payloads.
	localparam int unsigned OP_W     = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned COUNT_W  = 9;
	localparam int unsigned STATUS_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Request payload: one queue operation.
	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
	} deq_req_t;

	// Response payload: queue view after the operation.
	typedef struct packed {
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] back_value;
		logic [COUNT_W-1:0]        count;
		logic                      is_empty;
		logic [STATUS_W-1:0]       status;
	} deq_rsp_t;

	// Per-operation information passed from the pointer logic to the pipeline.
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
		logic [STATUS_W-1:0] status;
		logic                byp_front;
		logic                byp_back;
	} deq_info_t;

endpackage

`default_nettype wire

[sv/deq_stream_if.sv]
// Valid/ready stream interface used for the request and response channels.
`default_nettype none

interface deq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/deq_ram.sv]
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port; reads return the contents held before a same-cycle write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

[sv/deq_ctrl.sv]
// Ring pointer and count control: decodes one operation per transfer.
`default_nettype none

module deq_ctrl #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [deq_pkg::OP_W-1:0]      op,
	output logic                               wr_en,
	output logic      [AW-1:0]                 wr_addr,
	output logic      [AW-1:0]                 rd_front_addr,
	output logic      [AW-1:0]                 rd_back_addr,
	output deq_pkg::deq_info_t                 info
);
	import deq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = AW + 1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_n;
	logic [CW-1:0] count_n;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [SW-1:0] back_sum;
	logic [AW-1:0] back_pos;
	logic [SW-1:0] tail_sum;
	logic [AW-1:0] tail_pos;
	logic          full;
	logic          empty;
	logic          we;
	logic [STATUS_W-1:0] status;

	// Neighbouring ring positions of the current head and the slot after the back.
	always_comb begin
		full     = (count_q == CW'(DEPTH));
		empty    = (count_q == '0);
		head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
		head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
		back_sum = SW'(head_q) + SW'(count_q);
		back_pos = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
	end

	// Operation decode: next head, next count, write and status.
	always_comb begin
		head_n  = head_q;
		count_n = count_q;
		we      = 1'b0;
		wr_addr = back_pos;
		status  = ST_OK;
		unique case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					head_n  = head_dec;
					count_n = count_q + CW'(1);
					we      = 1'b1;
					wr_addr = head_dec;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_n = count_q + CW'(1);
					we      = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					head_n  = head_inc;
					count_n = count_q - CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_n = count_q - CW'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Position of the back value after the operation; meaningless when empty.
	always_comb begin
		tail_sum = SW'(head_n) + SW'(count_n) - SW'(1);
		tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	end

	assign wr_en         = fire && we;
	assign rd_front_addr = head_n;
	assign rd_back_addr  = tail_pos;

	// Information travelling alongside the read data.
	always_comb begin
		info.count     = COUNT_W'(count_n);
		info.is_empty  = (count_n == '0);
		info.status    = status;
		info.byp_front = we && (wr_addr == head_n);
		info.byp_back  = we && (wr_addr == tail_pos);
	end

	// Queue state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (fire) begin
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

endmodule

`default_nettype wire

[sv/double_ended_queue.sv]
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Requests arrive on req (op, value) and one response per request leaves on
// rsp (front_value, back_value, count, is_empty, status), both valid/ready.
// A transfer on req updates the ring pointers and count at once, and the new
// front and back entries are read from the ring memory at the same clock edge.
// The response register is loaded from the first stage once it is free or its
// response transfers, and rsp.valid is the output of that register.
// Throughput is one request per cycle unless rsp stalls: the ring memory has
// one write port and two read ports, so each operation uses the memory once.
// A push into a full queue is dropped with status 1, a pop from an empty
// queue is ignored with status 2; front and back read 0 when empty.
// Reset empties the queue and both pipeline stages; the entry memory is not
// cleared, since an entry is only read once it has been written.
// When rsp is stalled the pipeline holds; req.ready falls once both stages
// hold a response, and rises again in the cycle rsp.ready returns.
`default_nettype none

module double_ended_queue #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input wire logic  clk,
	input wire logic  arst_n,
	deq_stream_if.sink   req,
	deq_stream_if.source rsp
);
	import deq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic                fire;
	logic                go_s1;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_front_addr;
	logic [AW-1:0]       rd_back_addr;
	logic [VALUE_W-1:0]  rd_front;
	logic [VALUE_W-1:0]  rd_back;
	deq_info_t           info;
	deq_req_t            req_data;
	logic                valid_s1;
	deq_info_t           info_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic                valid_s2;
	deq_rsp_t            rsp_s2;
	deq_rsp_t            rsp_n;

	assign req_data = req.data;

	// Handshake: the first stage moves on when the response register is free or its response is taken.
	assign go_s1     = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || go_s1;
	assign fire      = req.valid && req.ready;

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.op           (req_data.op),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.rd_front_addr(rd_front_addr),
		.rd_back_addr (rd_back_addr),
		.info         (info)
	);

	deq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (wr_addr),
		.wdata  (req_data.value),
		.re     (fire),
		.raddr_a(rd_front_addr),
		.raddr_b(rd_back_addr),
		.rdata_a(rd_front),
		.rdata_b(rd_back)
	);

	// First stage: operation information alongside the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			info_s1  <= info;
			value_s1 <= req_data.value;
		end
	end

	// Response assembly, taking the pushed value where its write coincided with the memory read.
	always_comb begin
		rsp_n.count    = info_s1.count;
		rsp_n.is_empty = info_s1.is_empty;
		rsp_n.status   = info_s1.status;
		if (info_s1.is_empty) begin
			rsp_n.front_value = '0;
			rsp_n.back_value  = '0;
		end else begin
			rsp_n.front_value = $signed(info_s1.byp_front ? value_s1 : rd_front);
			rsp_n.back_value  = $signed(info_s1.byp_back ? value_s1 : rd_back);
		end
	end

	// Second stage: response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			rsp_s2 <= rsp_n;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

endmodule

`default_nettype wire

[sv/deq_checker.sv]
// Port-level checks on the queue responses, bound to the top level.
`default_nettype none

module deq_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire deq_pkg::deq_rsp_t rsp_data
);
	import deq_pkg::*;

	// An empty queue reports zero for both ends.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.is_empty |->
			rsp_data.front_value == '0 && rsp_data.back_value == '0)
		else $error("empty response with non-zero front or back value");

	// The empty flag agrees with the count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.is_empty == (rsp_data.count == '0))
		else $error("empty flag disagrees with count");

	// An ignored pop leaves the queue empty; a dropped push leaves it non-empty.
	a_status_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status != ST_EMPTY || rsp_data.is_empty) &&
			(rsp_data.status != ST_FULL || !rsp_data.is_empty))
		else $error("status inconsistent with queue occupancy");

	// A stalled response holds until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

`default_nettype wire

[sim/double_ended_queue_tb.sv]
// Self-checking testbench for the double-ended queue: directed steps, then random operations.
`default_nettype none

module double_ended_queue_tb;

	import deq_pkg::*;

	localparam int unsigned DEPTH          = DEPTH_DEFAULT;
	localparam int unsigned IDX_W          = $clog2(DEPTH);
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned PRINT_LIMIT    = 30;

	// Op codes the block does not define; they behave as a query.
	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

	// Views that can be stated directly for the opening steps.
	localparam deq_rsp_t VIEW_UNTYPED   = '0;
	localparam deq_rsp_t VIEW_EMPTY_OK  = '{32'sd0, 32'sd0, 9'd0, 1'b1, ST_OK};
	localparam deq_rsp_t VIEW_EMPTY_POP = '{32'sd0, 32'sd0, 9'd0, 1'b1, ST_EMPTY};
	localparam deq_rsp_t VIEW_ONE_MAX   = '{VALUE_MAX, VALUE_MAX, 9'd1, 1'b0, ST_OK};
	localparam deq_rsp_t VIEW_MIN_MAX   = '{VALUE_MIN, VALUE_MAX, 9'd2, 1'b0, ST_OK};

	typedef enum {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
		logic                      typed;
		deq_rsp_t                  want;
	} step_row_t;

	// Opening steps: empty-queue pops, spare codes, extremes, wrap of the head below zero.
	step_row_t opening_steps [0:21] = '{
		'{OP_QUERY,      32'sd0,          1'b1, VIEW_EMPTY_OK},
		'{OP_POP_FRONT,  32'sd0,          1'b1, VIEW_EMPTY_POP},
		'{OP_POP_BACK,   -32'sd1,         1'b1, VIEW_EMPTY_POP},
		'{OP_SPARE_5,    32'sd0,          1'b1, VIEW_EMPTY_OK},
		'{OP_SPARE_7,    -32'sd1,         1'b1, VIEW_EMPTY_OK},
		'{OP_PUSH_BACK,  VALUE_MAX,       1'b1, VIEW_ONE_MAX},
		'{OP_PUSH_FRONT, VALUE_MIN,       1'b1, VIEW_MIN_MAX},
		'{OP_QUERY,      32'sd0,          1'b1, VIEW_MIN_MAX},
		'{OP_SPARE_6,    32'sd5,          1'b0, VIEW_UNTYPED},
		'{OP_PUSH_BACK,  -32'sd1,         1'b0, VIEW_UNTYPED},
		'{OP_PUSH_FRONT, 32'sd0,          1'b0, VIEW_UNTYPED},
		'{OP_POP_BACK,   32'sd0,          1'b0, VIEW_UNTYPED},
		'{OP_POP_FRONT,  32'sd0,          1'b0, VIEW_UNTYPED},
		'{OP_POP_FRONT,  32'sd0,          1'b0, VIEW_UNTYPED},
		'{OP_POP_BACK,   32'sd0,          1'b1, VIEW_EMPTY_OK},
		'{OP_POP_BACK,   32'sd0,          1'b1, VIEW_EMPTY_POP},
		'{OP_PUSH_FRONT, 32'sh5555_5555,  1'b0, VIEW_UNTYPED},
		'{OP_PUSH_FRONT, 32'shAAAA_AAAA,  1'b0, VIEW_UNTYPED},
		'{OP_POP_FRONT,  32'sd0,          1'b0, VIEW_UNTYPED},
		'{OP_POP_FRONT,  32'sd0,          1'b1, VIEW_EMPTY_OK},
		'{OP_PUSH_BACK,  32'sd1,          1'b0, VIEW_UNTYPED},
		'{OP_POP_FRONT,  32'sd0,          1'b1, VIEW_EMPTY_OK}
	};

	logic clk;
	logic arst_n;

	deq_stream_if #(.payload_t(deq_req_t)) req_if ();
	deq_stream_if #(.payload_t(deq_rsp_t)) rsp_if ();

	double_ended_queue #(.DEPTH(DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the ring and its pointers.
	logic signed [VALUE_W-1:0] ring [DEPTH];
	logic [IDX_W-1:0]          ring_head;
	logic [COUNT_W-1:0]        ring_fill;

	deq_rsp_t pending_views [$];

	int unsigned mismatches;
	int unsigned ops_sent;
	int unsigned views_checked;
	int unsigned full_pushes;
	int unsigned empty_pops;
	int unsigned peak_fill;
	int unsigned input_stalls;
	int unsigned quiet_cycles;
	int unsigned no_gap_items;
	bit          gaps_on;
	bit          calm;
	bit          hold_off_req;
	bit          hold_busy;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Applies one operation to the shadow ring and returns the view the block should report.
	function automatic deq_rsp_t queue_view_after(input deq_req_t r);
		deq_rsp_t         v;
		logic [IDX_W-1:0] tail_pos;
		v.status = ST_OK;
		case (r.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (ring_fill == COUNT_W'(DEPTH)) begin
					v.status = ST_FULL;
					full_pushes++;
				end else if (r.op == OP_PUSH_FRONT) begin
					ring_head = ring_head - 1'b1;
					ring[ring_head] = r.value;
					ring_fill = ring_fill + 1'b1;
				end else begin
					tail_pos = ring_head + IDX_W'(ring_fill);
					ring[tail_pos] = r.value;
					ring_fill = ring_fill + 1'b1;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (ring_fill == '0) begin
					v.status = ST_EMPTY;
					empty_pops++;
				end else begin
					if (r.op == OP_POP_FRONT)
						ring_head = ring_head + 1'b1;
					ring_fill = ring_fill - 1'b1;
				end
			end
			default: ;
		endcase
		if (ring_fill > peak_fill)
			peak_fill = ring_fill;
		v.count = ring_fill;
		v.is_empty = (ring_fill == '0);
		if (v.is_empty) begin
			v.front_value = '0;
			v.back_value = '0;
		end else begin
			tail_pos = ring_head + IDX_W'(ring_fill - 1'b1);
			v.front_value = ring[ring_head];
			v.back_value = ring[tail_pos];
		end
		return v;
	endfunction

	// Draws a random operation, biased towards pushes or pops by the mix.
	function automatic deq_req_t random_op(input mix_t mix);
		deq_req_t    r;
		int unsigned roll;
		int unsigned push_pct;
		int unsigned pop_pct;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  begin push_pct = 86; pop_pct = 8;  end
			MIX_DRAIN: begin push_pct = 8;  pop_pct = 86; end
			default:   begin push_pct = 45; pop_pct = 45; end
		endcase
		if (roll < push_pct)
			r.op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		else if (roll < push_pct + pop_pct)
			r.op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
		else begin
			case ($urandom_range(0, 5))
				0:       r.op = OP_SPARE_5;
				1:       r.op = OP_SPARE_6;
				2:       r.op = OP_SPARE_7;
				default: r.op = OP_QUERY;
			endcase
		end
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0:       r.value = VALUE_MIN;
				1:       r.value = VALUE_MAX;
				2:       r.value = '0;
				default: r.value = '1;
			endcase
		end else
			r.value = $urandom;
		return r;
	endfunction

	// Offers one operation and waits for its transfer; valid is left high on return.
	task automatic offer(input deq_req_t r, input logic typed, input deq_rsp_t want);
		deq_rsp_t predicted;
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predicted = queue_view_after(r);
		pending_views.insert(pending_views.size(), typed ? want : predicted);
		ops_sent++;
	endtask

	// Occasionally drops valid for a burst of idle cycles.
	task automatic sender_gap();
		if (gaps_on && !calm && no_gap_items == 0 && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15))
				@(posedge clk);
		end
	endtask

	task automatic run_segment(input int unsigned items, input mix_t mix);
		for (int unsigned i = 0; i < items; i++) begin
			if (i % 40 == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			sender_gap();
			offer(random_op(mix), 1'b0, VIEW_UNTYPED);
			if (no_gap_items != 0)
				no_gap_items--;
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] response %0d: %s is %h, expected %h", $realtime, views_checked,
				field, got, want);
		mismatches++;
	endtask

	// Stimulus: reset, opening steps, then random phases with pressure and a calm tail.
	initial begin
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		ring_head     = '0;
		ring_fill     = '0;
		mismatches    = 0;
		ops_sent      = 0;
		views_checked = 0;
		full_pushes   = 0;
		empty_pops    = 0;
		peak_fill     = 0;
		no_gap_items  = 0;
		gaps_on       = 1'b1;
		calm          = 1'b0;
		hold_off_req  = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_steps[i]) begin
			sender_gap();
			offer('{opening_steps[i].op, opening_steps[i].value}, opening_steps[i].typed,
				opening_steps[i].want);
		end

		run_segment(60, MIX_EVEN);

		// Hold the response side off while the sender keeps offering, so the input stalls.
		req_if.valid <= 1'b0;
		hold_off_req = 1'b1;
		while (!hold_busy)
			@(posedge clk);
		no_gap_items = 24;
		run_segment(400, MIX_FILL);
		run_segment(400, MIX_DRAIN);
		run_segment(100, MIX_EVEN);

		// Pause until every outstanding response has been seen, then finish without idling.
		req_if.valid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		calm = 1'b1;
		run_segment(140, MIX_EVEN);
		req_if.valid <= 1'b0;

		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d operations, checked %0d responses, peak fill %0d of %0d entries.",
			ops_sent, views_checked, peak_fill, DEPTH);
		$display("Pushes refused when full: %0d, pops refused when empty: %0d,",
			full_pushes, empty_pops);
		$display("input stall cycles: %0d.", input_stalls);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Response side: random ready bursts, one long hold-off on request, none in the calm tail.
	initial begin
		rsp_if.ready = 1'b0;
		hold_busy    = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_busy = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_busy = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 15))
					@(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(1, calm ? 1 : 30))
					@(posedge clk);
			end
		end
	end

	// Compare each response transfer with the oldest expected view.
	always @(posedge clk) begin
		deq_rsp_t got;
		deq_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (pending_views.size() == 0) begin
				if (mismatches < PRINT_LIMIT)
					$display("[%0t] response with no operation outstanding", $realtime);
				mismatches++;
			end else begin
				want = pending_views[0];
				pending_views.delete(0);
				if (got.front_value !== want.front_value)
					report_mismatch("front_value", got.front_value, want.front_value);
				if (got.back_value !== want.back_value)
					report_mismatch("back_value", got.back_value, want.back_value);
				if (got.count !== want.count)
					report_mismatch("count", 32'(got.count), 32'(want.count));
				if (got.is_empty !== want.is_empty)
					report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				views_checked++;
			end
		end
	end

	// Watchdog: counts input stalls and ends the run when neither channel has a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
			input_stalls = 0;
		end else begin
			if (req_if.valid && !req_if.ready)
				input_stalls++;
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles = 0;
			else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("[%0t] no transfer for %0d cycles, %0d responses outstanding",
						$realtime, quiet_cycles, pending_views.size());
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

endmodule

`default_nettype wire
